@@ hw/rtl/two_voice_note_tone_generator_top_defines.svh @@
// ----------------------------------------------------------------------------
// Two-voice note tone generator: assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TWO_VOICE_NOTE_TONE_GENERATOR_TOP_DEFINES_SVH
`define TWO_VOICE_NOTE_TONE_GENERATOR_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define TVNTG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define TVNTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  `TVNTG_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ hw/rtl/tvntg_pkg.sv @@
// ----------------------------------------------------------------------------
// Two-voice note tone generator package
// Phase increments per note and quarter-wave cosine/sine tables in Q30.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tvntg_pkg;

  localparam int unsigned PHASE_BITS  = 32;
  localparam int unsigned TABLE_BITS  = 10;
  localparam int unsigned SAMPLE_RATE = 44100;

  localparam int unsigned NOTE_W    = 4;
  localparam int unsigned OCTAVE_W  = 3;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned NOTE_NUM  = 1 << NOTE_W;
  localparam int unsigned QUARTER_W = TABLE_BITS - 2;
  localparam int unsigned QUARTER   = 1 << QUARTER_W;
  localparam int unsigned COS_W     = 32;

  localparam longint Q30_ONE    = 64'sd1073741824;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;

  localparam logic [1:0] QUAD_COS     = 2'd0;
  localparam logic [1:0] QUAD_NEG_SIN = 2'd1;
  localparam logic [1:0] QUAD_NEG_COS = 2'd2;
  localparam logic [1:0] QUAD_SIN     = 2'd3;

  typedef logic [PHASE_BITS-1:0]   phase_t;
  typedef logic [NOTE_W-1:0]       note_t;
  typedef logic [OCTAVE_W-1:0]     octave_t;
  typedef logic signed [COS_W-1:0] cos_t;
  typedef phase_t                  inc_tab_t [NOTE_NUM];
  typedef cos_t                    quarter_tab_t [QUARTER];

  localparam int unsigned NOTE_HZ [NOTE_NUM] = '{
    440, 466, 494, 523, 523, 554, 587, 622,
    659, 698, 698, 740, 784, 831, 0, 0
  };

  function automatic inc_tab_t build_inc();
    inc_tab_t        tab;
    longint unsigned num;
    for (int i = 0; i < NOTE_NUM; i++) begin
      num    = (longint'(NOTE_HZ[i]) << PHASE_BITS) + longint'(SAMPLE_RATE / 2);
      tab[i] = PHASE_BITS'(num / SAMPLE_RATE);
    end
    return tab;
  endfunction

  localparam inc_tab_t NOTE_INC = build_inc();

  function automatic longint sq_step(longint term, longint x);
    longint t;
    t = term * x / Q30_ONE;
    return t * x / Q30_ONE;
  endfunction

  function automatic longint series_q30(longint x, bit odd);
    longint term;
    longint sum;
    term = odd ? x : Q30_ONE;
    sum  = term;
    if (odd) begin
      term = -sq_step(term, x) / 64'sd6;
      sum  = sum + term;
      term = -sq_step(term, x) / 64'sd20;
      sum  = sum + term;
      term = -sq_step(term, x) / 64'sd42;
      sum  = sum + term;
      term = -sq_step(term, x) / 64'sd72;
      sum  = sum + term;
      term = -sq_step(term, x) / 64'sd110;
      sum  = sum + term;
      term = -sq_step(term, x) / 64'sd156;
      sum  = sum + term;
      term = -sq_step(term, x) / 64'sd210;
      sum  = sum + term;
    end else begin
      term = -sq_step(term, x) / 64'sd2;
      sum  = sum + term;
      term = -sq_step(term, x) / 64'sd12;
      sum  = sum + term;
      term = -sq_step(term, x) / 64'sd30;
      sum  = sum + term;
      term = -sq_step(term, x) / 64'sd56;
      sum  = sum + term;
      term = -sq_step(term, x) / 64'sd90;
      sum  = sum + term;
      term = -sq_step(term, x) / 64'sd132;
      sum  = sum + term;
      term = -sq_step(term, x) / 64'sd182;
      sum  = sum + term;
    end
    return sum;
  endfunction

  function automatic quarter_tab_t build_quarter(bit odd);
    quarter_tab_t tab;
    longint       x;
    for (int r = 0; r < QUARTER; r++) begin
      x      = (longint'(r) * TWO_PI_Q30) >>> TABLE_BITS;
      tab[r] = COS_W'(series_q30(x, odd));
    end
    return tab;
  endfunction

  localparam quarter_tab_t COS_TAB = build_quarter(1'b0);
  localparam quarter_tab_t SIN_TAB = build_quarter(1'b1);

  function automatic phase_t voice_inc(note_t note, octave_t octave);
    phase_t base;
    base = NOTE_INC[note];
    if (octave == '0) begin
      return base >> 1;
    end
    return base << (octave - OCTAVE_W'(1));
  endfunction

  function automatic cos_t cos_lookup(phase_t phase);
    logic [TABLE_BITS-1:0] k;
    logic [1:0]            quad;
    logic [QUARTER_W-1:0]  r;
    cos_t                  val;
    k    = phase[PHASE_BITS-1 -: TABLE_BITS];
    quad = k[TABLE_BITS-1 -: 2];
    r    = k[QUARTER_W-1:0];
    unique case (quad)
      QUAD_COS:     val = COS_TAB[r];
      QUAD_NEG_SIN: val = -SIN_TAB[r];
      QUAD_NEG_COS: val = -COS_TAB[r];
      QUAD_SIN:     val = SIN_TAB[r];
      default:      val = COS_TAB[r];
    endcase
    return val;
  endfunction

endpackage

@@ hw/rtl/two_voice_note_tone_generator_top.sv @@
// ----------------------------------------------------------------------------
// Two-voice note tone generator
// Two phase accumulators address quarter-wave cosine/sine tables; the voices are
// averaged, scaled to 16 bits and saturated.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per sample tick:
//   restart flag, note code and octave for each voice. An item is taken at a
//   clock edge with in_valid_i high and in_stall_o low.
//   Output channel (out_valid_o / out_stall_i) returns one sample per item,
//   in order, from a result register.
//   out_valid_o is set in the cycle after an accept. Throughput: one item per
//   cycle unless the output stalls; table lookup, mix multiply and phase add
//   all sit in the single stage between the phase registers and the result
//   register. While the result register is full and out_stall_i is high,
//   in_stall_o is high and the pending sample holds; a new item is taken in
//   the same cycle that the waiting sample is taken.
//   Reset clears both phase accumulators and empties the result register.
//   Restart zeroes both phases before the sample of that item is formed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_voice_note_tone_generator_top_defines.svh"

module two_voice_note_tone_generator_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 restart_i,
  input  tvntg_pkg::note_t                     note_one_i,
  input  tvntg_pkg::octave_t                   octave_one_i,
  input  tvntg_pkg::note_t                     note_two_i,
  input  tvntg_pkg::octave_t                   octave_two_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [tvntg_pkg::SAMPLE_W-1:0] sample_o
);

  import tvntg_pkg::*;

  localparam int unsigned GAIN_W    = 17;
  localparam int unsigned SUM_W     = COS_W + 1;
  localparam int unsigned MIX_W     = SUM_W + GAIN_W;
  localparam int unsigned MIX_SHIFT = COS_W - 1;
  localparam int unsigned SCL_W     = MIX_W - MIX_SHIFT;

  localparam logic signed [GAIN_W-1:0] MIX_GAIN  = GAIN_W'(32767);
  localparam logic signed [MIX_W-1:0]  MIX_ROUND = MIX_W'((longint'(1) <<< MIX_SHIFT) - 1);
  localparam logic signed [SCL_W-1:0]  SMP_MAX   = SCL_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [SCL_W-1:0]  SMP_MIN   = -SCL_W'(1 << (SAMPLE_W - 1));

  logic                       in_accept;
  logic                       out_accept;
  phase_t                     phase_one_q, phase_one_d;
  phase_t                     phase_two_q, phase_two_d;
  phase_t                     phase_one_cur;
  phase_t                     phase_two_cur;
  cos_t                       cos_one;
  cos_t                       cos_two;
  logic signed [SUM_W-1:0]    mix_sum;
  logic signed [MIX_W-1:0]    mix_prod;
  logic signed [MIX_W-1:0]    mix_adj;
  logic signed [SCL_W-1:0]    mix_scaled;
  logic signed [SAMPLE_W-1:0] sample_d, sample_q;
  logic                       silent_one;
  logic                       out_valid_q, out_valid_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;

  assign phase_one_cur = restart_i ? '0 : phase_one_q;
  assign phase_two_cur = restart_i ? '0 : phase_two_q;

  assign cos_one = cos_lookup(phase_one_cur);
  assign cos_two = cos_lookup(phase_two_cur);

  assign mix_sum    = SUM_W'(cos_one) + SUM_W'(cos_two);
  assign mix_prod   = MIX_W'(mix_sum) * MIX_W'(MIX_GAIN);
  assign mix_adj    = mix_prod + (mix_prod[MIX_W-1] ? MIX_ROUND : '0);
  assign mix_scaled = mix_adj[MIX_W-1:MIX_SHIFT];
  assign silent_one = (NOTE_HZ[note_one_i] == 0);

  always_comb begin
    priority if (silent_one) begin
      sample_d = '0;
    end else if (mix_scaled > SMP_MAX) begin
      sample_d = SMP_MAX[SAMPLE_W-1:0];
    end else if (mix_scaled < SMP_MIN) begin
      sample_d = SMP_MIN[SAMPLE_W-1:0];
    end else begin
      sample_d = mix_scaled[SAMPLE_W-1:0];
    end
  end

  assign phase_one_d = phase_one_cur + voice_inc(note_one_i, octave_one_i);
  assign phase_two_d = phase_two_cur + voice_inc(note_two_i, octave_two_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (out_accept) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_one_q <= '0;
      phase_two_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        phase_one_q <= phase_one_d;
        phase_two_q <= phase_two_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= sample_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  `TVNTG_ASSERT_NEXT(a_accept_fills, in_accept, out_valid_o, "accepted item produced no sample")
  `TVNTG_ASSERT_NEXT(a_silent_zero, in_accept && silent_one, sample_o == '0,
                     "silent voice one gave a nonzero sample")
  `TVNTG_ASSERT_NEXT(a_restart_phase, in_accept && restart_i,
                     phase_one_q == $past(voice_inc(note_one_i, octave_one_i)) &&
                     phase_two_q == $past(voice_inc(note_two_i, octave_two_i)),
                     "restart did not start phases from zero")
  `TVNTG_ASSERT_NEXT(a_phase_hold, !in_accept, $stable(phase_one_q) && $stable(phase_two_q),
                     "phase moved without an accepted item")

endmodule

@@ tb/tone_checker.sv @@
// ----------------------------------------------------------------------------
// Two-voice tone generator checker
// Watches both channels, predicts each sample from the accepted item and
// compares it with the next sample that leaves the block, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tone_checker
  import tvntg_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic                       restart_i,
  input  note_t                      note_one_i,
  input  octave_t                    octave_one_i,
  input  note_t                      note_two_i,
  input  octave_t                    octave_two_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int unsigned TONE_HZ [16] = '{
    440, 466, 494, 523, 523, 554, 587, 622,
    659, 698, 698, 740, 784, 831, 0, 0
  };
  localparam longint SAMPLE_MAX = 64'sd32767;
  localparam longint SAMPLE_MIN = -64'sd32768;

  phase_t                     phase_one;
  phase_t                     phase_two;
  logic signed [SAMPLE_W-1:0] expected_samples [$];

  function automatic phase_t tone_increment(note_t note, octave_t octave);
    longint unsigned hz;
    longint unsigned step;
    hz   = TONE_HZ[note];
    step = ((hz << PHASE_BITS) + longint'(SAMPLE_RATE / 2)) / longint'(SAMPLE_RATE);
    if (octave == 0) begin
      step = step >> 1;
    end else begin
      step = step << (int'(octave) - 1);
    end
    return phase_t'(step);
  endfunction

  function automatic longint taylor_q30(longint x, bit odd_series);
    longint term;
    longint acc;
    longint k;
    term = odd_series ? x : Q30_ONE;
    acc  = term;
    for (int n = 1; n <= 7; n++) begin
      k    = odd_series ? longint'(2 * n) : longint'(2 * n - 1);
      term = term * x / Q30_ONE;
      term = term * x / Q30_ONE;
      term = -term / (k * (k + 1));
      acc  = acc + term;
    end
    return acc;
  endfunction

  function automatic longint cosine_q30(phase_t phase);
    logic [TABLE_BITS-1:0] idx;
    logic [1:0]            quad;
    logic [TABLE_BITS-3:0] offs;
    longint                x;
    idx  = phase[PHASE_BITS-1 -: TABLE_BITS];
    quad = idx[TABLE_BITS-1 -: 2];
    offs = idx[TABLE_BITS-3:0];
    x    = (longint'(offs) * TWO_PI_Q30) / (longint'(1) << TABLE_BITS);
    case (quad)
      QUAD_COS:     return taylor_q30(x, 1'b0);
      QUAD_NEG_SIN: return -taylor_q30(x, 1'b1);
      QUAD_NEG_COS: return -taylor_q30(x, 1'b0);
      default:      return taylor_q30(x, 1'b1);
    endcase
  endfunction

  task automatic predict_sample(logic restart, note_t n1, octave_t o1, note_t n2,
                                octave_t o2);
    longint mix;
    longint scaled;
    if (restart) begin
      phase_one = '0;
      phase_two = '0;
    end
    scaled = 0;
    if (TONE_HZ[n1] != 0) begin
      mix    = cosine_q30(phase_one) + cosine_q30(phase_two);
      scaled = mix * 32767 / (Q30_ONE * 2);
      if (scaled > SAMPLE_MAX) scaled = SAMPLE_MAX;
      if (scaled < SAMPLE_MIN) scaled = SAMPLE_MIN;
    end
    phase_one = phase_one + tone_increment(n1, o1);
    phase_two = phase_two + tone_increment(n2, o2);
    expected_samples.push_back(scaled[SAMPLE_W-1:0]);
  endtask

  task automatic log_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    phase_one    = '0;
    phase_two    = '0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      phase_one = '0;
      phase_two = '0;
      expected_samples.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          log_mismatch("unexpected sample", int'(sample_i), 0);
        end else begin
          if (sample_i !== expected_samples[0]) begin
            log_mismatch("sample", int'(sample_i), int'(expected_samples[0]));
          end
          void'(expected_samples.pop_front());
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_sample(restart_i, note_one_i, octave_one_i, note_two_i, octave_two_i);
      end
    end
    pending_o = expected_samples.size();
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Two-voice tone generator testbench
// Drives directed and random note sequences with random gaps and stalls,
// including a long output hold, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import tvntg_pkg::*;

  localparam int      ITEM_TOTAL   = 1800;
  localparam int      HOLD_CYCLES  = 48;
  localparam int      STUCK_LIMIT  = 1000;
  localparam int      DRAIN_CYCLES = 4;
  localparam note_t   NOTE_LOWEST  = 4'd0;
  localparam note_t   NOTE_HIGHEST = 4'd13;
  localparam note_t   NOTE_REST    = 4'd14;
  localparam note_t   NOTE_REST2   = 4'd15;
  localparam octave_t OCT_HALF     = 3'd0;
  localparam octave_t OCT_BASE     = 3'd1;
  localparam octave_t OCT_TOP      = 3'd7;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic                       restart_i;
  note_t                      note_one_i;
  octave_t                    octave_one_i;
  note_t                      note_two_i;
  octave_t                    octave_two_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [SAMPLE_W-1:0] sample_o;

  int fail_count;
  int pending;
  int items_sent;
  int stuck_cycles;
  int hold_left;
  bit idle_en;
  bit hold_req;

  two_voice_note_tone_generator_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .restart_i    (restart_i),
    .note_one_i   (note_one_i),
    .octave_one_i (octave_one_i),
    .note_two_i   (note_two_i),
    .octave_two_i (octave_two_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_o     (sample_o)
  );

  tone_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .restart_i    (restart_i),
    .note_one_i   (note_one_i),
    .octave_one_i (octave_one_i),
    .note_two_i   (note_two_i),
    .octave_two_i (octave_two_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_i     (sample_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  task automatic send_item(logic restart, note_t n1, octave_t o1, note_t n2, octave_t o2);
    while (idle_en && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    restart_i    <= restart;
    note_one_i   <= n1;
    octave_one_i <= o1;
    note_two_i   <= n2;
    octave_two_i <= o2;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  // output side: random stalls, plus one long hold on request
  initial begin
    out_stall_i = 1'b0;
    hold_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idle_en && ($urandom_range(99) < 21);
      end
    end
  end

  initial begin
    stuck_cycles = 0;
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int      len;
    bit      pressure_done;
    note_t   n1;
    note_t   n2;
    octave_t o1;
    octave_t o2;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    restart_i     = 1'b0;
    note_one_i    = '0;
    octave_one_i  = '0;
    note_two_i    = '0;
    octave_two_i  = '0;
    idle_en       = 1'b1;
    hold_req      = 1'b0;
    items_sent    = 0;
    pressure_done = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: every note code on both voices, every octave, silences
    for (int c = 0; c < 16; c++) begin
      send_item(c == 0, note_t'(c), octave_t'(c % 8), note_t'(15 - c), octave_t'(7 - c % 8));
    end
    send_item(1'b1, NOTE_LOWEST, OCT_BASE, NOTE_LOWEST, OCT_BASE);
    repeat (3) send_item(1'b0, NOTE_HIGHEST, OCT_TOP, NOTE_HIGHEST, OCT_TOP);
    send_item(1'b0, NOTE_REST2, OCT_TOP, NOTE_HIGHEST, OCT_TOP);
    send_item(1'b0, NOTE_REST, OCT_HALF, NOTE_HIGHEST, OCT_TOP);
    send_item(1'b1, NOTE_LOWEST, OCT_HALF, NOTE_REST, OCT_HALF);
    send_item(1'b0, NOTE_HIGHEST, OCT_HALF, NOTE_REST2, OCT_TOP);

    // random: mostly whole notes with restart on the first tick, some noise
    while (items_sent < ITEM_TOTAL) begin
      idle_en = !(items_sent >= 600 && items_sent < 900);
      if (!pressure_done && items_sent >= 1200) begin
        hold_req      = 1'b1;
        pressure_done = 1'b1;
      end
      if ($urandom_range(99) < 85) begin
        len = $urandom_range(1, 24);
        n1  = ($urandom_range(99) < 90) ? note_t'($urandom_range(0, 13))
                                        : note_t'($urandom_range(14, 15));
        n2  = ($urandom_range(99) < 90) ? note_t'($urandom_range(0, 13))
                                        : note_t'($urandom_range(14, 15));
        o1  = octave_t'($urandom_range(0, 7));
        o2  = ($urandom_range(99) < 30) ? o1 : octave_t'($urandom_range(0, 7));
        for (int i = 0; i < len; i++) begin
          send_item(i == 0, n1, o1, n2, o2);
        end
      end else begin
        send_item(1'($urandom_range(0, 1)), note_t'($urandom_range(0, 15)),
                  octave_t'($urandom_range(0, 7)), note_t'($urandom_range(0, 15)),
                  octave_t'($urandom_range(0, 7)));
      end
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
